@@ src/matrix_keypad_debounce_repeat_core_assert.svh @@
// assertion macros for the keypad qualifier checker
// depends on nothing; taken in by the checker file
`ifndef MATRIX_KEYPAD_DEBOUNCE_REPEAT_CORE_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_REPEAT_CORE_ASSERT_SVH

// same-cycle implication
`define MKDR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define MKDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ src/mkdr_pkg.sv @@
// shared types and constants for the keypad debounce and repeat qualifier
// no dependencies
package mkdr_pkg;

   localparam int FUNC_W    = 2;
   localparam int SAMPLE_W  = 6;
   localparam int KEY_W     = 4;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] DEBOUNCE_RELOAD_RST = 8'd2;
   localparam logic [COUNT_W-1:0] SPEED_RELOAD_RST    = 8'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_POLL      = 2'd0,
      FUNC_FAST_TICK = 2'd1,
      FUNC_SLOW_TICK = 2'd2
   } func_type;

   typedef enum logic [KEY_W-1:0] {
      KEY_NONE    = 4'd0,
      KEY_CONFIG  = 4'd1,
      KEY_BAND    = 4'd2,
      KEY_SCAN    = 4'd3,
      KEY_UP      = 4'd4,
      KEY_MODE    = 4'd5,
      KEY_DOWN    = 4'd6,
      KEY_UP_DOWN = 4'd7,
      KEY_FAST_UP = 4'd8,
      KEY_FAST_DN = 4'd9
   } key_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_RELOAD = 1'b0,
      CSR_SPEED_RELOAD    = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type     func;
      key_code_type first_key;
      key_code_type second_key;
   } step_type;

   typedef struct packed {
      key_code_type key_code;
      logic         click;
   } result_type;

endpackage

@@ src/mkdr_if.sv @@
// handshake channel interfaces: poll/tick requests, results, register writes
// depends on mkdr_pkg
interface mkdr_req_if;
   logic                         valid;
   logic                         ready;
   logic [mkdr_pkg::FUNC_W-1:0]   func;
   logic [mkdr_pkg::SAMPLE_W-1:0] first_sample;
   logic [mkdr_pkg::SAMPLE_W-1:0] second_sample;

   modport source (output valid, func, first_sample, second_sample, input ready);
   modport sink   (input valid, func, first_sample, second_sample, output ready);
endinterface

interface mkdr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mkdr_pkg::KEY_W-1:0] key_code;
   logic                       click;

   modport source (output valid, key_code, click, input ready);
   modport sink   (input valid, key_code, click, output ready);
endinterface

interface mkdr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mkdr_pkg::CSR_IDX_W-1:0] index;
   logic [mkdr_pkg::COUNT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/mkdr_decode.sv @@
// decodes one 6-bit matrix sample to a key code, last key in scan order wins, but up with down (no mode) gives up-down
// depends on mkdr_pkg
module mkdr_decode (
   input  logic [mkdr_pkg::SAMPLE_W-1:0] sample,
   output mkdr_pkg::key_code_type        key
);

   always_comb begin
      key = mkdr_pkg::KEY_NONE;
      if (sample[0]) key = mkdr_pkg::KEY_CONFIG;
      if (sample[1]) key = mkdr_pkg::KEY_BAND;
      if (sample[2]) key = mkdr_pkg::KEY_SCAN;
      if (sample[3]) key = mkdr_pkg::KEY_UP;
      if (sample[4]) key = mkdr_pkg::KEY_MODE;
      if (sample[5]) begin
         key = (key == mkdr_pkg::KEY_UP) ? mkdr_pkg::KEY_UP_DOWN : mkdr_pkg::KEY_DOWN;
      end
   end

endmodule

@@ src/mkdr_qualify.sv @@
// debounce and hold-to-repeat state, reload registers and the per-beat update
// depends on mkdr_pkg
module mkdr_qualify (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [mkdr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mkdr_pkg::COUNT_W-1:0]   csr_data,
   input  logic                           step_valid,
   input  mkdr_pkg::step_type             step,
   output mkdr_pkg::result_type           result
);

   logic [mkdr_pkg::COUNT_W-1:0] debounce_reload_ff;
   logic [mkdr_pkg::COUNT_W-1:0] speed_reload_ff;
   logic [mkdr_pkg::COUNT_W-1:0] debounce_count_ff, debounce_count_in;
   logic [mkdr_pkg::COUNT_W-1:0] speed_count_ff, speed_count_in;
   mkdr_pkg::key_code_type       held_key_ff, held_key_in;
   mkdr_pkg::key_code_type       matched;

   always_comb begin
      debounce_count_in = debounce_count_ff;
      speed_count_in    = speed_count_ff;
      held_key_in       = held_key_ff;
      result.key_code   = mkdr_pkg::KEY_NONE;
      result.click      = 1'b0;
      matched = (step.first_key == step.second_key) ? step.first_key : mkdr_pkg::KEY_NONE;
      case (step.func)
         mkdr_pkg::FUNC_FAST_TICK: begin
            if (debounce_count_ff != '0) debounce_count_in = debounce_count_ff - 8'd1;
         end
         mkdr_pkg::FUNC_SLOW_TICK: begin
            if (speed_count_ff != '0) speed_count_in = speed_count_ff - 8'd1;
         end
         mkdr_pkg::FUNC_POLL: begin
            if (debounce_count_ff == '0) begin
               result.key_code = matched;
               if (matched != mkdr_pkg::KEY_NONE) begin
                  result.click      = 1'b1;
                  debounce_count_in = debounce_reload_ff;
                  if (matched == held_key_ff) begin
                     // repeat codes skip debounce
                     if (speed_count_ff == '0 && matched == mkdr_pkg::KEY_UP) begin
                        debounce_count_in = '0;
                        result.key_code   = mkdr_pkg::KEY_FAST_UP;
                     end else if (speed_count_ff == '0 && matched == mkdr_pkg::KEY_DOWN) begin
                        debounce_count_in = '0;
                        result.key_code   = mkdr_pkg::KEY_FAST_DN;
                     end
                  end else begin
                     speed_count_in = speed_reload_ff;
                     held_key_in    = matched;
                  end
               end else begin
                  held_key_in = mkdr_pkg::KEY_NONE;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_reload_ff <= mkdr_pkg::DEBOUNCE_RELOAD_RST;
         speed_reload_ff    <= mkdr_pkg::SPEED_RELOAD_RST;
         debounce_count_ff  <= '0;
         speed_count_ff     <= '0;
         held_key_ff        <= mkdr_pkg::KEY_NONE;
      end else begin
         if (csr_write) begin
            case (mkdr_pkg::csr_index_type'(csr_index))
               mkdr_pkg::CSR_DEBOUNCE_RELOAD: debounce_reload_ff <= csr_data;
               mkdr_pkg::CSR_SPEED_RELOAD:    speed_reload_ff    <= csr_data;
               default: ;
            endcase
         end
         if (step_valid) begin
            debounce_count_ff <= debounce_count_in;
            speed_count_ff    <= speed_count_in;
            held_key_ff       <= held_key_in;
         end
      end
   end

endmodule

@@ src/matrix_keypad_debounce_repeat_core.sv @@
// keypad debounce and repeat qualifier top: input register, decode, result register
// depends on mkdr_pkg, mkdr_if, mkdr_decode, mkdr_qualify
// beats go through both registers; one beat per cycle while rsp_bus.ready holds
// while a result waits to be taken, a full input register holds and stalls requests
// reset clears both counters, the held key and pending beats; reloads go to 2 and 5
module matrix_keypad_debounce_repeat_core (
   input  logic       clock,
   input  logic       reset,
   mkdr_req_if.sink   req_bus,
   mkdr_rsp_if.source rsp_bus,
   mkdr_csr_if.sink   csr_bus
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [mkdr_pkg::FUNC_W-1:0]   s1_func_ff;
   logic [mkdr_pkg::SAMPLE_W-1:0] s1_first_ff;
   logic [mkdr_pkg::SAMPLE_W-1:0] s1_second_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   mkdr_pkg::result_type          rsp_result_ff;
   mkdr_pkg::result_type          result;
   mkdr_pkg::step_type            step;
   logic                          req_take;
   logic                          advance;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   assign step.func = mkdr_pkg::func_type'(s1_func_ff);

   mkdr_decode u_decode_first (
      .sample (s1_first_ff),
      .key    (step.first_key)
   );

   mkdr_decode u_decode_second (
      .sample (s1_second_ff),
      .key    (step.second_key)
   );

   mkdr_qualify u_qualify (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_bus.valid && csr_bus.ready),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .step_valid (advance),
      .step       (step),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_func_ff   <= req_bus.func;
         s1_first_ff  <= req_bus.first_sample;
         s1_second_ff <= req_bus.second_sample;
      end
      if (advance) rsp_result_ff <= result;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.key_code = rsp_result_ff.key_code;
   assign rsp_bus.click    = rsp_result_ff.click;

endmodule

@@ src/mkdr_checker.sv @@
// port-level checker for the keypad qualifier, bound to the top level
// depends on mkdr_pkg and matrix_keypad_debounce_repeat_core_assert.svh
`include "matrix_keypad_debounce_repeat_core_assert.svh"

module mkdr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [mkdr_pkg::KEY_W-1:0] rsp_key_code,
   input logic                       rsp_click
);

   logic rsp_has_key;

   assign rsp_has_key = (rsp_key_code != mkdr_pkg::KEY_NONE);

   `MKDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MKDR_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, ##1 rsp_valid)
   `MKDR_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `MKDR_ASSERT_IMPLIES(a_click_iff_key, clock, reset, rsp_valid, rsp_click == rsp_has_key)

endmodule

bind matrix_keypad_debounce_repeat_core mkdr_checker u_mkdr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_key_code (rsp_bus.key_code),
   .rsp_click    (rsp_bus.click)
);
